// ===== src/bstk_pkg.sv =====
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared types and constants for the bounded stack with position access:
// command and status codes, controller states and the control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bstk_pkg;

    // field widths of the stream words
    localparam int COMMAND_W   = 3;
    localparam int WORD_W      = 32;
    localparam int POS_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_CHANGE = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the input word
        logic execute;   // apply the command to the stack
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== src/bstk_ctrl.sv =====
// ----------------------------------------------------------------------------
// bstk_ctrl
// Sequencer for the stack: takes a word, runs the execute step, then holds
// the result until the output side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bstk_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output bstk_pkg::ctrl_cmd_t     ctrl
);
    import bstk_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (m_tready)
                begin
                    state_next = s_tvalid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        ctrl.execute = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_EXEC:
            begin
                ctrl.execute = 1'b1;
            end
            S_RESP:
            begin
                m_tvalid = 1'b1;
                s_tready = m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        ctrl.capture = s_tvalid & s_tready;
    end

endmodule

`default_nettype wire

// ===== src/bstk_datapath.sv =====
// ----------------------------------------------------------------------------
// bstk_datapath
// Entry memory, top pointer and result registers. The execute step updates
// the pointer, writes the memory and issues a registered read for peek.
// ----------------------------------------------------------------------------
`default_nettype none

module bstk_datapath
#(
    parameter int DEPTH      = 8,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bstk_pkg::ctrl_cmd_t               ctrl,
    input  wire logic [bstk_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic [bstk_pkg::COMMAND_W-1:0]    s_tuser,
    output logic      [bstk_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import bstk_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW = $clog2(DEPTH + 1);
    localparam int PW = (TW > POS_W) ? TW : POS_W;
    localparam int CW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

    // captured input word
    logic [COMMAND_W-1:0]  cmd_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [POS_W-1:0]      pos_reg;

    // stack state and results
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [TW-1:0]         top_reg;
    logic [TW-1:0]         top_next;
    logic [DATA_WIDTH-1:0] rd_reg;
    logic                  peek_ok_reg;
    logic                  peek_ok_next;
    status_t               status_reg;
    status_t               status_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [PW-1:0]         top_ext;
    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         idx_full;
    logic [AW-1:0]         idx;
    logic                  is_empty;
    logic                  is_full;
    logic [DATA_WIDTH-1:0] wr_word;
    logic [WORD_W-1:0]     read_word;

    // input capture
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= s_tuser;
            word_reg <= s_tdata[WORD_W-1:0];
            pos_reg  <= s_tdata[WORD_W+POS_W-1:WORD_W];
        end
    end

    // position decode
    assign top_ext  = PW'(top_reg);
    assign pos_ext  = PW'(pos_reg);
    assign idx_full = top_ext - pos_ext;
    assign idx      = idx_full[AW-1:0];
    assign wr_word  = DATA_WIDTH'(word_reg[CW-1:0]);
    assign is_empty = (top_reg == '0);
    assign is_full  = (top_reg == TW'(DEPTH));

    // command decode
    always_comb
    begin
        top_next     = top_reg;
        status_next  = ST_OK;
        peek_ok_next = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = idx;
        unique case (cmd_reg)
            CMD_PUSH:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = top_reg[AW-1:0];
                    top_next = top_reg + TW'(1);
                end
            end
            CMD_POP:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    top_next = top_reg - TW'(1);
                end
            end
            CMD_PEEK, CMD_CHANGE:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pos_ext == '0 || pos_ext > top_ext)
                begin
                    status_next = ST_BADPOS;
                end
                else if (cmd_reg == CMD_PEEK)
                begin
                    peek_ok_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                top_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // top pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else if (ctrl.execute)
        begin
            top_reg <= top_next;
        end
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= wr_word;
            end
            rd_reg <= mem[idx];
        end
    end

    // result flags
    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            status_reg  <= status_next;
            peek_ok_reg <= peek_ok_next;
        end
    end

    // result word
    assign read_word = peek_ok_reg ? WORD_W'(rd_reg[CW-1:0]) : '0;
    assign m_tdata   = {is_empty, is_full, FILL_W'(top_reg), status_reg, read_word};

endmodule

`default_nettype wire

// ===== src/bounded_stack_with_position_access.sv =====
// Result: the result word is offered in the response state, after the
// execute state that follows acceptance of the input word.
// Flow: a new word is taken only when idle or in the response state while
// the output side takes the result; the execute step comes between words.
// Reset: top pointer cleared so the stack is empty; entries are not cleared
// and no clearing pass runs, the block takes words at once.
// ----------------------------------------------------------------------------
// bounded_stack_with_position_access
// Fixed-depth stack with push, pop, peek and change at a depth from the top,
// and clear. Every input word gives one result word.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_position_access
#(
    parameter int DEPTH      = 8,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // data_word [31:0], position [35:32], zero [39:36]
    input  wire logic [bstk_pkg::IN_TDATA_W-1:0]   s_tdata,
    // command [2:0]
    input  wire logic [bstk_pkg::COMMAND_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // read_word [31:0], status [33:32], fill_count [37:34],
    // is_full [38], is_empty [39]
    output logic      [bstk_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import bstk_pkg::*;

    ctrl_cmd_t ctrl;

    // sequencer
    bstk_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    // stack storage and result
    bstk_datapath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire
